// File: hdl/midpoint_ellipse_rasterizer_macros.svh
// Assertion macros used by the ellipse rasterizer core.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define EMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define EMR_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/emr_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package emr_pkg;

    localparam int DW        = 48;  // decision and slope width
    localparam int AXIS_W    = 10;
    localparam int CENTER_W  = 11;
    localparam int SQ_W      = 2 * AXIS_W;
    localparam int STEP_X_W  = 11;
    localparam int STEP_Y_W  = 12;
    localparam int PIX_W     = 13;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 13;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_Y = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_REG1 = 2'd1,
        PH_REG2 = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_SQC,
        ST_INIT,
        ST_RES1,
        ST_D2B,
        ST_D2C,
        ST_D2D,
        ST_D2E,
        ST_D2F,
        ST_D2G,
        ST_RES2,
        ST_CHECK,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [AXIS_W-1:0]   semi_axis_x;
        logic [AXIS_W-1:0]   semi_axis_y;
    } t_cfg;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    last_of_point;
        logic                    ellipse_done;
    } t_pix;

endpackage

// File: hdl/emr_mul.sv
// Shared signed multiplier with registered product.
module emr_mul (
    input  logic                                i_clk,
    input  logic signed [emr_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [emr_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [emr_pkg::DW-1:0]       o_prod
);

    logic signed [emr_pkg::MUL_P_W-1:0] w_prod;
    logic signed [emr_pkg::DW-1:0]      r_prod;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= {{(emr_pkg::DW - emr_pkg::MUL_P_W){w_prod[emr_pkg::MUL_P_W-1]}}, w_prod};
    end

    assign o_prod = r_prod;

endmodule

// File: hdl/emr_core.sv
// Sequencer and datapath of the midpoint ellipse rasterizer.
`include "midpoint_ellipse_rasterizer_macros.svh"

module emr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  emr_pkg::t_cfg   i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_restart,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output emr_pkg::t_pix   o_pix
);

    emr_pkg::t_state r_state, n_state;
    emr_pkg::t_phase r_phase;

    logic                                  r_restart;
    logic                                  r_post;   // resolving after an update
    logic                                  r_p1;
    logic                                  r_br;
    logic [1:0]                            r_cnt;
    logic [emr_pkg::SQ_W-1:0]              r_a2, r_b2;
    logic [emr_pkg::STEP_X_W-1:0]          r_step_x, r_px;
    logic signed [emr_pkg::STEP_Y_W-1:0]   r_step_y, r_py;
    logic signed [emr_pkg::DW-1:0]         r_sdx, r_sdy, r_dec, r_acc;

    logic signed [emr_pkg::MUL_A_W-1:0]    w_mul_a;
    logic signed [emr_pkg::MUL_B_W-1:0]    w_mul_b;
    logic signed [emr_pkg::DW-1:0]         w_prod;
    logic signed [emr_pkg::DW-1:0]         w_a2x, w_b2x;
    logic signed [emr_pkg::MUL_B_W-1:0]    w_tx, w_ty;
    logic                                  w_res1_go;
    logic                                  w_dec_pos;

    emr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_a2x = $signed({{(emr_pkg::DW - emr_pkg::SQ_W){1'b0}}, r_a2});
    assign w_b2x = $signed({{(emr_pkg::DW - emr_pkg::SQ_W){1'b0}}, r_b2});
    assign w_tx  = $signed({1'b0, r_step_x, 1'b1});
    assign w_ty  = $signed({r_step_y[emr_pkg::STEP_Y_W-1], r_step_y})
                   - $signed(emr_pkg::MUL_B_W'(1));
    assign w_res1_go = (r_phase == emr_pkg::PH_REG1) && !(r_sdx < r_sdy);
    assign w_dec_pos = !r_dec[emr_pkg::DW-1] && (r_dec != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emr_pkg::ST_IDLE:  if (i_in_valid) n_state = emr_pkg::ST_SQA;
            emr_pkg::ST_SQA:   n_state = emr_pkg::ST_SQB;
            emr_pkg::ST_SQB:   n_state = emr_pkg::ST_SQC;
            emr_pkg::ST_SQC:   n_state = r_restart ? emr_pkg::ST_INIT : emr_pkg::ST_CHECK;
            emr_pkg::ST_INIT:  n_state = emr_pkg::ST_RES1;
            emr_pkg::ST_RES1:  n_state = w_res1_go ? emr_pkg::ST_D2B : emr_pkg::ST_RES2;
            emr_pkg::ST_D2B:   n_state = emr_pkg::ST_D2C;
            emr_pkg::ST_D2C:   n_state = emr_pkg::ST_D2D;
            emr_pkg::ST_D2D:   n_state = emr_pkg::ST_D2E;
            emr_pkg::ST_D2E:   n_state = emr_pkg::ST_D2F;
            emr_pkg::ST_D2F:   n_state = emr_pkg::ST_D2G;
            emr_pkg::ST_D2G:   n_state = emr_pkg::ST_RES2;
            emr_pkg::ST_RES2:  n_state = r_post ? emr_pkg::ST_EMIT : emr_pkg::ST_CHECK;
            emr_pkg::ST_CHECK: begin
                if (r_phase == emr_pkg::PH_REG1 || r_phase == emr_pkg::PH_REG2)
                    n_state = emr_pkg::ST_UPD1;
                else
                    n_state = emr_pkg::ST_IDLE;
            end
            emr_pkg::ST_UPD1:  n_state = emr_pkg::ST_UPD2;
            emr_pkg::ST_UPD2:  n_state = emr_pkg::ST_UPD3;
            emr_pkg::ST_UPD3:  n_state = emr_pkg::ST_RES1;
            emr_pkg::ST_EMIT:  if (i_out_ready && r_cnt == 2'd3) n_state = emr_pkg::ST_IDLE;
            default:           n_state = emr_pkg::ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_in_ready  = (r_state == emr_pkg::ST_IDLE);
        o_out_valid = (r_state == emr_pkg::ST_EMIT);
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            emr_pkg::ST_SQA: begin
                w_mul_a = $signed({{(emr_pkg::MUL_A_W - emr_pkg::AXIS_W){1'b0}}, i_cfg.semi_axis_x});
                w_mul_b = $signed({{(emr_pkg::MUL_B_W - emr_pkg::AXIS_W){1'b0}}, i_cfg.semi_axis_x});
            end
            emr_pkg::ST_SQB: begin
                w_mul_a = $signed({{(emr_pkg::MUL_A_W - emr_pkg::AXIS_W){1'b0}}, i_cfg.semi_axis_y});
                w_mul_b = $signed({{(emr_pkg::MUL_B_W - emr_pkg::AXIS_W){1'b0}}, i_cfg.semi_axis_y});
            end
            emr_pkg::ST_SQC, emr_pkg::ST_D2E: begin
                w_mul_a = $signed({{(emr_pkg::MUL_A_W - emr_pkg::SQ_W){1'b0}}, r_a2});
                w_mul_b = $signed({{(emr_pkg::MUL_B_W - emr_pkg::AXIS_W){1'b0}}, i_cfg.semi_axis_y});
            end
            emr_pkg::ST_RES1: begin
                w_mul_a = $signed({{(emr_pkg::MUL_A_W - emr_pkg::SQ_W){1'b0}}, r_b2});
                w_mul_b = w_tx;
            end
            emr_pkg::ST_D2B: begin
                w_mul_a = $signed(w_prod[emr_pkg::MUL_A_W-1:0]);
                w_mul_b = w_tx;
            end
            emr_pkg::ST_D2C: begin
                w_mul_a = $signed({{(emr_pkg::MUL_A_W - emr_pkg::SQ_W){1'b0}}, r_a2});
                w_mul_b = w_ty;
            end
            emr_pkg::ST_D2D: begin
                w_mul_a = $signed(w_prod[emr_pkg::MUL_A_W-1:0]);
                w_mul_b = w_ty;
            end
            emr_pkg::ST_D2F: begin
                w_mul_a = $signed(w_prod[emr_pkg::MUL_A_W-1:0]);
                w_mul_b = $signed({{(emr_pkg::MUL_B_W - emr_pkg::AXIS_W){1'b0}}, i_cfg.semi_axis_y});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= emr_pkg::ST_IDLE;
            r_phase <= emr_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                emr_pkg::ST_IDLE: r_post <= 1'b0;
                emr_pkg::ST_INIT: r_phase <= emr_pkg::PH_REG1;
                emr_pkg::ST_D2G:  r_phase <= emr_pkg::PH_REG2;
                emr_pkg::ST_RES2: begin
                    if (r_phase == emr_pkg::PH_REG2 && r_step_y[emr_pkg::STEP_Y_W-1])
                        r_phase <= emr_pkg::PH_IDLE;
                end
                emr_pkg::ST_UPD3: r_post <= 1'b1;
                emr_pkg::ST_EMIT: if (i_out_ready) r_cnt <= r_cnt + 2'd1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            emr_pkg::ST_IDLE: if (i_in_valid) r_restart <= i_restart;
            emr_pkg::ST_SQB:  r_a2 <= w_prod[emr_pkg::SQ_W-1:0];
            emr_pkg::ST_SQC:  r_b2 <= w_prod[emr_pkg::SQ_W-1:0];
            emr_pkg::ST_INIT: begin
                r_step_x <= '0;
                r_step_y <= $signed({{(emr_pkg::STEP_Y_W - emr_pkg::AXIS_W){1'b0}},
                                     i_cfg.semi_axis_y});
                r_sdx    <= '0;
                r_sdy    <= w_prod <<< 1;
                r_dec    <= (w_b2x <<< 2) - (w_prod <<< 2) + w_a2x;
            end
            emr_pkg::ST_D2C:  r_acc <= w_prod;
            emr_pkg::ST_D2E:  r_acc <= r_acc + (w_prod <<< 2);
            emr_pkg::ST_D2G:  r_dec <= r_acc - (w_prod <<< 2);
            emr_pkg::ST_CHECK: begin
                r_px <= r_step_x;
                r_py <= r_step_y;
            end
            emr_pkg::ST_UPD1: begin
                r_p1 <= (r_phase == emr_pkg::PH_REG1);
                if (r_phase == emr_pkg::PH_REG1) begin
                    r_br     <= r_dec[emr_pkg::DW-1];
                    r_step_x <= r_step_x + 1'b1;
                    r_sdx    <= r_sdx + (w_b2x <<< 1);
                    if (!r_dec[emr_pkg::DW-1]) begin
                        r_step_y <= r_step_y - $signed(emr_pkg::STEP_Y_W'(1));
                        r_sdy    <= r_sdy - (w_a2x <<< 1);
                    end
                end else begin
                    r_br     <= w_dec_pos;
                    r_step_y <= r_step_y - $signed(emr_pkg::STEP_Y_W'(1));
                    r_sdy    <= r_sdy - (w_a2x <<< 1);
                    if (!w_dec_pos) begin
                        r_step_x <= r_step_x + 1'b1;
                        r_sdx    <= r_sdx + (w_b2x <<< 1);
                    end
                end
            end
            emr_pkg::ST_UPD2: begin
                unique case ({r_p1, r_br})
                    2'b11:   r_acc <= r_sdx + w_b2x;
                    2'b10:   r_acc <= r_sdx - r_sdy + w_b2x;
                    2'b01:   r_acc <= w_a2x - r_sdy;
                    default: r_acc <= r_sdx - r_sdy + w_a2x;
                endcase
            end
            emr_pkg::ST_UPD3: r_dec <= r_dec + (r_acc <<< 2);
            default: ;
        endcase
    end

    // pixel order: (+x,+y), (-x,+y), (+x,-y), (-x,-y)
    logic [emr_pkg::PIX_W-1:0] w_cx, w_cy, w_ox, w_oy;
    assign w_cx = {2'b00, i_cfg.center_x};
    assign w_cy = {2'b00, i_cfg.center_y};
    assign w_ox = {2'b00, r_px};
    assign w_oy = {r_py[emr_pkg::STEP_Y_W-1], r_py};

    always_comb begin
        o_pix.pixel_x       = $signed(r_cnt[0] ? (w_cx - w_ox) : (w_cx + w_ox));
        o_pix.pixel_y       = $signed(r_cnt[1] ? (w_cy - w_oy) : (w_cy + w_oy));
        o_pix.last_of_point = (r_cnt == 2'd3);
        o_pix.ellipse_done  = (r_phase == emr_pkg::PH_IDLE);
    end

    `EMR_NEVER(a_no_overlap, o_in_ready && o_out_valid, "input and output active together")
    `EMR_ASSERT(a_busy_after_accept, i_in_valid && o_in_ready |=> !o_in_ready, "ready after accept")
    `EMR_ASSERT(a_last_ends, o_out_valid && i_out_ready && o_pix.last_of_point |=> o_in_ready, "block not idle after last pixel")
    `EMR_ASSERT(a_phase_held, r_state == emr_pkg::ST_EMIT && $past(r_state == emr_pkg::ST_EMIT) |-> $stable(r_phase), "phase moved during emit")
    `EMR_ASSERT(a_update_live, r_state == emr_pkg::ST_UPD1 |-> (r_phase == emr_pkg::PH_REG1 || r_phase == emr_pkg::PH_REG2), "update outside a region")

endmodule

// File: hdl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: ports and configuration registers.
//
//  channel  | direction | carries
//  s_axis   | in        | tdata[0] restart
//  m_axis   | out       | tdata pixel_x, pixel_y; tlast last_of_point; tuser ellipse_done
//  cfg      | in        | index 0..3: center_x, center_y, semi_axis_x, semi_axis_y
//
// A restart does more work than an advance before its first pixel, and both do more when
// the point enters region two; all products share one 33x13 multiplier.
// Pixels leave one per cycle while m_axis is ready (stalls hold them), so the next request
// is taken only after the last pixel of a point or after a tick that draws nothing.
// Synchronous reset clears configuration and leaves the block idle/done.
// Configuration is accepted every cycle and must only change while idle.
module midpoint_ellipse_rasterizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,   // [0] restart
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [31:0]                        o_m_axis_tdata,   // [12:0] pixel_x, [25:13] pixel_y
    output logic                               o_m_axis_tlast,
    output logic                               o_m_axis_tuser,   // [0] ellipse_done
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [emr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [emr_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    emr_pkg::t_cfg r_cfg;
    emr_pkg::t_pix w_pix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                emr_pkg::CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data;
                emr_pkg::CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data;
                emr_pkg::CFG_SEMI_AXIS_X: r_cfg.semi_axis_x <= i_cfg_data[emr_pkg::AXIS_W-1:0];
                emr_pkg::CFG_SEMI_AXIS_Y: r_cfg.semi_axis_y <= i_cfg_data[emr_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    emr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_restart   (i_s_axis_tdata[0]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_pix       (w_pix)
    );

    assign o_m_axis_tdata = {6'b0, w_pix.pixel_y, w_pix.pixel_x};
    assign o_m_axis_tlast = w_pix.last_of_point;
    assign o_m_axis_tuser = w_pix.ellipse_done;

endmodule

// File: tb/midpoint_ellipse_rasterizer_tb.sv
// Self-checking testbench for the midpoint ellipse rasterizer.
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 48;     // restart, region crossing and emit, with margin
    localparam int MODE_POINTS   = 60;     // least number of points drawn per idling mode

    typedef enum logic [1:0] {RK_ADVANCE, RK_RESTART, RK_CFG} t_row_kind;

    // One directed row. Typed rows carry their pixels: cnt copies of (ex, ey, edone).
    typedef struct packed {
        t_row_kind                     kind;
        logic [emr_pkg::CFG_IDX_W-1:0] idx;    // register, cfg rows only
        logic [emr_pkg::CFG_DAT_W-1:0] val;
        logic                          typed;
        logic [2:0]                    cnt;
        logic [emr_pkg::PIX_W-1:0]     ex;
        logic [emr_pkg::PIX_W-1:0]     ey;
        logic                          edone;
    } t_row;

    localparam int N_ROWS = 33;
    localparam t_row DIRECTED [N_ROWS] = '{
        // after reset: idle, nothing drawn
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b1, 3'd0, 13'd0, 13'd0, 1'b0},
        // zero axes at the origin: one point, final
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b1, 3'd4, 13'd0, 13'd0, 1'b1},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b1, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_CENTER_X, 11'd2047, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_CENTER_Y, 11'd2047, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b1, 3'd4, 13'd2047, 13'd2047, 1'b1},
        // top data bit is dropped on the axis registers
        '{RK_CFG, emr_pkg::CFG_SEMI_AXIS_X, 11'h7ff, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_SEMI_AXIS_Y, 11'h7ff, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        // centre moved mid-ellipse: negative pixels from here
        '{RK_CFG, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_CENTER_Y, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        // zero horizontal axis: vertical line, region one skipped
        '{RK_CFG, emr_pkg::CFG_SEMI_AXIS_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_SEMI_AXIS_Y, 11'd5, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b1, 3'd0, 13'd0, 13'd0, 1'b0},
        // zero vertical axis: single point, final on the first tick
        '{RK_CFG, emr_pkg::CFG_SEMI_AXIS_X, 11'd7, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_SEMI_AXIS_Y, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_CENTER_X, 11'd300, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_CFG, emr_pkg::CFG_CENTER_Y, 11'd40, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_ADVANCE, emr_pkg::CFG_CENTER_X, 11'd0, 1'b1, 3'd0, 13'd0, 13'd0, 1'b0},
        '{RK_RESTART, emr_pkg::CFG_CENTER_X, 11'd0, 1'b0, 3'd0, 13'd0, 13'd0, 1'b0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [7:0]                    i_s_axis_tdata;    // [0] restart
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [31:0]                   o_m_axis_tdata;    // [12:0] pixel_x, [25:13] pixel_y
    logic                          o_m_axis_tlast;    // last_of_point
    logic                          o_m_axis_tuser;    // [0] ellipse_done
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [emr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [emr_pkg::CFG_DAT_W-1:0] i_cfg_data;

    midpoint_ellipse_rasterizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow of the configuration and of the stepping state.
    logic [emr_pkg::CENTER_W-1:0]        cfg_cx, cfg_cy;
    logic [emr_pkg::AXIS_W-1:0]          cfg_ax, cfg_ay;
    logic [emr_pkg::STEP_X_W-1:0]        pos_x;
    logic signed [emr_pkg::STEP_Y_W-1:0] pos_y;
    logic [emr_pkg::DW-1:0]              grad_x, grad_y, dec;
    emr_pkg::t_phase                     region;

    emr_pkg::t_pix pending_pixels[$];

    int src_idle_pct;
    int sink_stall_pct;
    int errors;
    int cycle_count;
    int ticks_sent;
    int points_drawn;
    int pixels_checked;
    int regs_written;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Region one ends once the x slope catches up; region two ends below the axis.
    task automatic settle_region();
        longint av, bv, tx, ty, d2;
        if (region == emr_pkg::PH_REG1 && !($signed(grad_x) < $signed(grad_y))) begin
            av = longint'(cfg_ax);
            bv = longint'(cfg_ay);
            tx = 2 * longint'(pos_x) + 1;
            ty = longint'(pos_y) - 1;
            d2 = bv * bv * tx * tx + 4 * av * av * ty * ty - 4 * av * av * bv * bv;
            dec = d2[emr_pkg::DW-1:0];
            region = emr_pkg::PH_REG2;
        end
        if (region == emr_pkg::PH_REG2 && pos_y < 0)
            region = emr_pkg::PH_IDLE;
    endtask

    // Pixels of one tick, then the midpoint step to the next point.
    task automatic plot_point(input bit restart, output emr_pkg::t_pix pts[4], output int n);
        logic [emr_pkg::DW-1:0] a2, b2;
        int                     xp, xn, yp, yn;
        a2 = cfg_ax * cfg_ax;
        b2 = cfg_ay * cfg_ay;
        n  = 0;
        if (restart) begin
            pos_x  = '0;
            pos_y  = cfg_ay;
            grad_x = '0;
            grad_y = 2 * a2 * cfg_ay;
            dec    = 4 * b2 - 4 * a2 * cfg_ay + a2;
            region = emr_pkg::PH_REG1;
            settle_region();
        end
        if (region == emr_pkg::PH_REG1 || region == emr_pkg::PH_REG2) begin
            xp = int'(cfg_cx) + int'(pos_x);
            xn = int'(cfg_cx) - int'(pos_x);
            yp = int'(cfg_cy) + int'(pos_y);
            yn = int'(cfg_cy) - int'(pos_y);
            pts[0] = '{xp[emr_pkg::PIX_W-1:0], yp[emr_pkg::PIX_W-1:0], 1'b0, 1'b0};
            pts[1] = '{xn[emr_pkg::PIX_W-1:0], yp[emr_pkg::PIX_W-1:0], 1'b0, 1'b0};
            pts[2] = '{xp[emr_pkg::PIX_W-1:0], yn[emr_pkg::PIX_W-1:0], 1'b0, 1'b0};
            pts[3] = '{xn[emr_pkg::PIX_W-1:0], yn[emr_pkg::PIX_W-1:0], 1'b1, 1'b0};
            n = 4;
            if (region == emr_pkg::PH_REG1) begin
                pos_x  = pos_x + 1'b1;
                grad_x = grad_x + 2 * b2;
                if (dec[emr_pkg::DW-1]) begin
                    dec = dec + 4 * (grad_x + b2);
                end else begin
                    pos_y  = pos_y - $signed(emr_pkg::STEP_Y_W'(1));
                    grad_y = grad_y - 2 * a2;
                    dec    = dec + 4 * (grad_x - grad_y + b2);
                end
            end else begin
                pos_y  = pos_y - $signed(emr_pkg::STEP_Y_W'(1));
                grad_y = grad_y - 2 * a2;
                if (!dec[emr_pkg::DW-1] && dec != '0) begin
                    dec = dec + 4 * (a2 - grad_y);
                end else begin
                    pos_x  = pos_x + 1'b1;
                    grad_x = grad_x + 2 * b2;
                    dec    = dec + 4 * (grad_x - grad_y + a2);
                end
            end
            settle_region();
            if (region == emr_pkg::PH_IDLE) begin
                for (int k = 0; k < 4; k++)
                    pts[k].ellipse_done = 1'b1;
            end
            points_drawn++;
        end
    endtask

    // Entered and left at a falling edge. Valid stays high after acceptance;
    // the next call or a drain decides what follows.
    task automatic send_tick(input bit restart, input bit typed = 1'b0,
                             input int typed_cnt = 0, input emr_pkg::t_pix typed_pix = '0);
        emr_pkg::t_pix pts[4];
        emr_pkg::t_pix p;
        int            n;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'd0, restart};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        ticks_sent++;
        plot_point(restart, pts, n);
        if (typed) begin
            for (int k = 0; k < typed_cnt; k++) begin
                p = typed_pix;
                p.last_of_point = (k == 3);
                pending_pixels.push_back(p);
            end
        end else begin
            for (int k = 0; k < n; k++)
                pending_pixels.push_back(pts[k]);
        end
    endtask

    task automatic write_reg(input logic [emr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [emr_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        regs_written++;
        case (idx)
            emr_pkg::CFG_CENTER_X:    cfg_cx = val;
            emr_pkg::CFG_CENTER_Y:    cfg_cy = val;
            emr_pkg::CFG_SEMI_AXIS_X: cfg_ax = val[emr_pkg::AXIS_W-1:0];
            emr_pkg::CFG_SEMI_AXIS_Y: cfg_ay = val[emr_pkg::AXIS_W-1:0];
            default: ;
        endcase
    endtask

    // Wait out every pending pixel, then the work of a tick that draws nothing.
    task automatic drain_and_settle();
        i_s_axis_tvalid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [emr_pkg::CFG_DAT_W-1:0] pick_center();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return emr_pkg::CFG_DAT_W'($urandom);
    endfunction

    // Mostly small axes so an ellipse closes within a few dozen ticks.
    function automatic logic [emr_pkg::CFG_DAT_W-1:0] pick_axis(inout bit big);
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            big = 1'b1;
            return emr_pkg::CFG_DAT_W'($urandom);
        end
        if (r < 15) begin
            big = 1'b1;
            return '1;
        end
        return emr_pkg::CFG_DAT_W'($urandom_range(0, 10))
               | (emr_pkg::CFG_DAT_W'($urandom_range(1)) << emr_pkg::AXIS_W);
    endfunction

    task automatic trace_ellipse();
        bit big;
        int limit;
        int steps;
        big = 1'b0;
        write_reg(emr_pkg::CFG_CENTER_X, pick_center());
        write_reg(emr_pkg::CFG_CENTER_Y, pick_center());
        write_reg(emr_pkg::CFG_SEMI_AXIS_X, pick_axis(big));
        write_reg(emr_pkg::CFG_SEMI_AXIS_Y, pick_axis(big));
        if (cfg_ax <= 40 && cfg_ay <= 40) big = 1'b0;
        limit = big ? $urandom_range(2, 6) : 400;
        send_tick(1'b1);
        steps = 0;
        while ((region == emr_pkg::PH_REG1 || region == emr_pkg::PH_REG2) && steps < limit) begin
            // occasional restart in the middle of an ellipse
            send_tick($urandom_range(99) < 3);
            steps++;
        end
        repeat ($urandom_range(0, 2)) send_tick(1'b0);
        drain_and_settle();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d pixels still pending",
                     cycle_count, pending_pixels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin : pixel_monitor
        emr_pkg::t_pix want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("unrequested pixel x=%0d y=%0d",
                              $signed(o_m_axis_tdata[12:0]), $signed(o_m_axis_tdata[25:13])));
            end else begin
                want = pending_pixels.pop_front();
                if (o_m_axis_tdata[12:0] !== want.pixel_x)
                    flag_mismatch($sformatf("pixel_x %0d, wanted %0d",
                                  $signed(o_m_axis_tdata[12:0]), want.pixel_x));
                if (o_m_axis_tdata[25:13] !== want.pixel_y)
                    flag_mismatch($sformatf("pixel_y %0d, wanted %0d",
                                  $signed(o_m_axis_tdata[25:13]), want.pixel_y));
                if (o_m_axis_tlast !== want.last_of_point)
                    flag_mismatch($sformatf("tlast %b, wanted %b",
                                  o_m_axis_tlast, want.last_of_point));
                if (o_m_axis_tuser !== want.ellipse_done)
                    flag_mismatch($sformatf("ellipse_done %b, wanted %b",
                                  o_m_axis_tuser, want.ellipse_done));
            end
        end
    end

    initial begin
        int   mode_start;
        t_row row;
        int   src_modes  [4] = '{0, 88, 0, 7};
        int   sink_modes [4] = '{0, 0, 88, 7};

        errors          = 0;
        cycle_count     = 0;
        ticks_sent      = 0;
        points_drawn    = 0;
        pixels_checked  = 0;
        regs_written    = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = emr_pkg::CFG_CENTER_X;
        i_cfg_data      = '0;

        cfg_cx = '0;
        cfg_cy = '0;
        cfg_ax = '0;
        cfg_ay = '0;
        pos_x  = '0;
        pos_y  = '0;
        grad_x = '0;
        grad_y = '0;
        dec    = '0;
        region = emr_pkg::PH_IDLE;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == RK_CFG) begin
                drain_and_settle();
                write_reg(row.idx, row.val);
            end else begin
                send_tick(row.kind == RK_RESTART, row.typed, int'(row.cnt),
                          '{row.ex, row.ey, 1'b0, row.edone});
            end
        end
        drain_and_settle();

        for (int m = 0; m < 4; m++) begin
            src_idle_pct   = src_modes[m];
            sink_stall_pct = sink_modes[m];
            mode_start     = points_drawn;
            while (points_drawn - mode_start < MODE_POINTS)
                trace_ellipse();
        end

        sink_stall_pct = 0;
        drain_and_settle();

        $display("%0d ticks drew %0d points; %0d pixels checked after %0d register writes",
                 ticks_sent, points_drawn, pixels_checked, regs_written);
        $display("idling modes: none, sender gaps, receiver stalls, both light");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
